// ----- rtl/wcwm_pkg.sv -----
// ----------------------------------------------------------------------------
// wcwm_pkg
// Shared types and codes for the word concatenation window matcher.
// ----------------------------------------------------------------------------
package wcwm_pkg;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_TEXT    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  localparam logic REG_WORD_LEN   = 1'b0;
  localparam logic REG_WORD_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_ISSUE,
    ST_EVAL,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_dict;
    logic start_text;
    logic restart;
    logic init_check;
    logic next_j;
    logic next_c;
    logic next_k;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic short_text;
    logic j_done;
    logic j_used;
    logic eq;
    logic last_c;
    logic last_k;
    logic out_busy;
  } sts_t;

endpackage

// ----- rtl/wcwm_ram.sv -----
// ----------------------------------------------------------------------------
// wcwm_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module wcwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/wcwm_ctrl.sv -----
// ----------------------------------------------------------------------------
// wcwm_ctrl
// Sequencer: accepts items, steps the chunk/word/char search, emits results.
// ----------------------------------------------------------------------------
module wcwm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [1:0]      in_op,
  output logic            in_stall,
  input  wcwm_pkg::sts_t  sts,
  output wcwm_pkg::cmd_t  cmd
);

  wcwm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wcwm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != wcwm_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wcwm_pkg::ST_IDLE: begin
        if (in_valid && (in_op == wcwm_pkg::OP_TEXT)) state_nxt = wcwm_pkg::ST_START;
      end
      wcwm_pkg::ST_START: begin
        state_nxt = sts.short_text ? wcwm_pkg::ST_IDLE : wcwm_pkg::ST_ISSUE;
      end
      wcwm_pkg::ST_ISSUE: begin
        priority if (sts.j_done) state_nxt = wcwm_pkg::ST_IDLE;
        else if (!sts.j_used)    state_nxt = wcwm_pkg::ST_EVAL;
      end
      wcwm_pkg::ST_EVAL: begin
        if (sts.eq && sts.last_c && sts.last_k) state_nxt = wcwm_pkg::ST_EMIT;
        else                                    state_nxt = wcwm_pkg::ST_ISSUE;
      end
      wcwm_pkg::ST_EMIT: begin
        if (!sts.out_busy) state_nxt = wcwm_pkg::ST_IDLE;
      end
      default: state_nxt = wcwm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      wcwm_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_dict  = (in_op == wcwm_pkg::OP_LOAD);
          cmd.start_text = (in_op == wcwm_pkg::OP_TEXT);
          cmd.restart    = (in_op == wcwm_pkg::OP_RESTART);
        end
      end
      wcwm_pkg::ST_START: cmd.init_check = 1'b1;
      wcwm_pkg::ST_ISSUE: begin
        if (!sts.j_done && sts.j_used) cmd.next_j = 1'b1;
      end
      wcwm_pkg::ST_EVAL: begin
        priority if (!sts.eq)   cmd.next_j = 1'b1;
        else if (sts.last_c)    cmd.next_k = 1'b1;
        else                    cmd.next_c = 1'b1;
      end
      wcwm_pkg::ST_EMIT: begin
        if (!sts.out_busy) cmd.emit = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/wcwm_dp.sv -----
// ----------------------------------------------------------------------------
// wcwm_dp
// Datapath: config, dictionary and window RAMs, search counters, result reg.
// ----------------------------------------------------------------------------
module wcwm_dp #(
  parameter int MAX_WORDS    = 16,
  parameter int MAX_WORD_LEN = 16,
  parameter int POS_WIDTH    = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [4:0]           cfg_wdata,
  input  logic [3:0]           in_word_index,
  input  logic [3:0]           in_char_pos,
  input  logic [7:0]           in_char_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [POS_WIDTH-1:0] out_start_pos,
  input  wcwm_pkg::cmd_t       cmd,
  output wcwm_pkg::sts_t       sts
);

  localparam int WIW   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CPW   = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int DAW   = WIW + CPW;
  localparam int STORE = MAX_WORDS * MAX_WORD_LEN;
  localparam int WAW   = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int JW    = $clog2(MAX_WORDS + 1);
  localparam int LW    = $clog2(MAX_WORD_LEN + 1);
  localparam int TW    = $clog2(STORE + 1);

  logic [4:0]           wl_raw_r, wc_raw_r;
  logic [LW-1:0]        wl;
  logic [JW-1:0]        wc;
  logic [WAW-1:0]       head_r;
  logic [16:0]          seen_r;
  logic [POS_WIDTH-1:0] pos_r, cur_r;
  logic [TW-1:0]        total_r, kb_r;
  logic [JW-1:0]        k_r, j_r;
  logic [CPW-1:0]       c_r;
  logic [MAX_WORDS-1:0] tally_r;
  logic                 out_valid_r;
  logic [POS_WIDTH-1:0] out_pos_r;
  logic                 dict_we;
  logic [DAW-1:0]       dict_waddr, dict_raddr;
  logic [WAW-1:0]       win_raddr;
  logic [7:0]           dict_rdata, win_rdata;

  // register values out of range are clamped
  always_comb begin
    if (wl_raw_r == 5'd0)                   wl = LW'(1);
    else if (int'(wl_raw_r) > MAX_WORD_LEN) wl = LW'(MAX_WORD_LEN);
    else                                    wl = LW'(wl_raw_r);
    if (wc_raw_r == 5'd0)                   wc = JW'(1);
    else if (int'(wc_raw_r) > MAX_WORDS)    wc = JW'(MAX_WORDS);
    else                                    wc = JW'(wc_raw_r);
  end

  assign dict_we    = cmd.load_dict && (int'(in_word_index) < MAX_WORDS)
                      && (int'(in_char_pos) < MAX_WORD_LEN);
  assign dict_waddr = {WIW'(in_word_index), CPW'(in_char_pos)};
  assign dict_raddr = {j_r[WIW-1:0], c_r};
  // window offset p from its start sits at head - total + p (circular buffer)
  assign win_raddr  = WAW'(head_r - WAW'(total_r) + WAW'(kb_r) + WAW'(c_r));

  wcwm_ram #(.WIDTH(8), .DEPTH(1 << DAW)) u_dict (
    .clk   (clk),
    .we    (dict_we),
    .waddr (dict_waddr),
    .wdata (in_char_value),
    .raddr (dict_raddr),
    .rdata (dict_rdata)
  );

  wcwm_ram #(.WIDTH(8), .DEPTH(1 << WAW)) u_win (
    .clk   (clk),
    .we    (cmd.start_text),
    .waddr (head_r),
    .wdata (in_char_value),
    .raddr (win_raddr),
    .rdata (win_rdata)
  );

  always_comb begin
    sts.short_text = seen_r < 17'(total_r);
    sts.j_done     = (j_r == wc);
    sts.j_used     = tally_r[j_r[WIW-1:0]];
    sts.eq         = (dict_rdata == win_rdata);
    sts.last_c     = (LW'(c_r) == wl - LW'(1));
    sts.last_k     = (k_r == wc - JW'(1));
    sts.out_busy   = out_valid_r && out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_raw_r    <= 5'd1;
      wc_raw_r    <= 5'd1;
      head_r      <= '0;
      seen_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == wcwm_pkg::REG_WORD_LEN) wl_raw_r <= cfg_wdata;
        else                                     wc_raw_r <= cfg_wdata;
      end
      if (cmd.restart) begin
        seen_r <= '0;
        pos_r  <= '0;
      end
      if (cmd.start_text) begin
        head_r <= head_r + WAW'(1);
        if (seen_r != '1) seen_r <= seen_r + 17'd1;
        if (pos_r != '1)  pos_r  <= pos_r + POS_WIDTH'(1);
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (cmd.emit)                  out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_text) begin
      cur_r   <= pos_r;
      total_r <= TW'(wl) * TW'(wc);
    end
    if (cmd.init_check) begin
      k_r     <= '0;
      j_r     <= '0;
      c_r     <= '0;
      kb_r    <= '0;
      tally_r <= '0;
    end
    if (cmd.next_j) begin
      j_r <= j_r + JW'(1);
      c_r <= '0;
    end
    if (cmd.next_c) c_r <= c_r + CPW'(1);
    if (cmd.next_k) begin
      tally_r[j_r[WIW-1:0]] <= 1'b1;
      k_r  <= k_r + JW'(1);
      kb_r <= TW'(kb_r + TW'(wl));
      j_r  <= '0;
      c_r  <= '0;
    end
    if (cmd.emit) out_pos_r <= POS_WIDTH'(cur_r - POS_WIDTH'(total_r) + POS_WIDTH'(1));
  end

  assign out_valid     = out_valid_r;
  assign out_start_pos = out_pos_r;

endmodule

// ----- rtl/word_concatenation_window_matcher_top.sv -----
// ----------------------------------------------------------------------------
// word_concatenation_window_matcher_top
// Streams text through a window and reports windows made of dictionary words.
// ----------------------------------------------------------------------------
// Load and restart items are taken without leaving idle. A text item starts
// a search only when the window is full: for each chunk every unused
// dictionary word is compared byte by byte until a mismatch, through the
// registered read ports of the dictionary and window RAMs. Already used
// dictionary words are skipped, the search ends when a chunk finds no word,
// and a full match hands a result to the output register. A result waits
// in an output register while the next item is taken; a new result stalls
// only if that register is still full.
module word_concatenation_window_matcher_top #(
  parameter int MAX_WORDS    = 16,
  parameter int MAX_WORD_LEN = 16,
  parameter int POS_WIDTH    = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [4:0]           cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_op,
  input  logic [3:0]           in_word_index,
  input  logic [3:0]           in_char_pos,
  input  logic [7:0]           in_char_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [POS_WIDTH-1:0] out_start_pos
);

  wcwm_pkg::cmd_t cmd;
  wcwm_pkg::sts_t sts;

  wcwm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  wcwm_dp #(
    .MAX_WORDS    (MAX_WORDS),
    .MAX_WORD_LEN (MAX_WORD_LEN),
    .POS_WIDTH    (POS_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_word_index (in_word_index),
    .in_char_pos   (in_char_pos),
    .in_char_value (in_char_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_start_pos (out_start_pos),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule
